FILE: rtl/core/ucd_pkg.sv
// Shared types, calendar constants and reciprocal helpers for the seconds-to-date unit.
package ucd_pkg;

  // Number of register stages from the input request to the result register.
  localparam int unsigned NSTAGE = 14;

  // Calendar constants of the era arithmetic.
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam int unsigned EPOCH_SHIFT   = 719468;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned DAYS_PER_4Y   = 1460;
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_YEAR = 365;

  // Every 32-bit count lands in the era starting in 1600 or the one starting in 2000.
  localparam int unsigned ERA_BASE      = 4;
  localparam logic [15:0] ERA_SPLIT_DAY =
      16'((ERA_BASE + 1) * DAYS_PER_ERA - EPOCH_SHIFT);
  localparam logic [17:0] DOE_AT_EPOCH  = 18'(EPOCH_SHIFT - ERA_BASE * DAYS_PER_ERA);
  localparam logic [11:0] ERA_YEAR_LO   = 12'(ERA_BASE * 400);
  localparam logic [11:0] ERA_YEAR_HI   = 12'((ERA_BASE + 1) * 400);

  // Seconds per day is 128 * 675: the low seven bits are shifted off first.
  localparam int unsigned DAY_SHIFT = 40;
  localparam logic [31:0] DAY_RCP   = 32'((64'd1 << DAY_SHIFT) / 64'd675);

  // Rounded-up reciprocals scaled by 2^32; exact for every operand that reaches them.
  localparam logic [31:0] RCP_3600 = 32'(((64'd1 << 32) + 64'd3599) / 64'd3600);
  localparam logic [31:0] RCP_60   = 32'(((64'd1 << 32) + 64'd59) / 64'd60);
  localparam logic [31:0] RCP_1460 = 32'(((64'd1 << 32) + 64'd1459) / 64'd1460);
  localparam logic [31:0] RCP_365  = 32'(((64'd1 << 32) + 64'd364) / 64'd365);
  localparam logic [31:0] RCP_100  = 32'(((64'd1 << 32) + 64'd99) / 64'd100);
  localparam logic [31:0] RCP_153  = 32'(((64'd1 << 32) + 64'd152) / 64'd153);
  localparam logic [31:0] RCP_5    = 32'(((64'd1 << 32) + 64'd4) / 64'd5);

  // One finished date and time of day.
  typedef struct packed {
    logic        date_valid;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } result_t;

  // Quotient by a constant through its scaled reciprocal.
  function automatic logic [31:0] rdiv(input logic [31:0] x, input logic [31:0] rcp);
    logic [63:0] p;
    p = 64'(x) * 64'(rcp);
    return p[63:32];
  endfunction

endpackage

FILE: rtl/core/ucd_stream_if.sv
// Valid/ready channels that carry the seconds count in and the civil date out.
interface ucd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ucd_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output date_valid, output year, output month,
                  output day_of_month, output hour, output minute, output second,
                  input ready);
  modport sink (input valid, input date_valid, input year, input month,
                input day_of_month, input hour, input minute, input second,
                output ready);
endinterface

FILE: rtl/core/ucd_datapath.sv
// Payload stages of the seconds-to-date pipeline; each stage loads when it advances.
module ucd_datapath (
  input  logic                       clk,
  input  logic [ucd_pkg::NSTAGE-1:0] adv,
  input  logic [31:0]                secs_in,
  output ucd_pkg::result_t           result
);

  localparam int unsigned N = ucd_pkg::NSTAGE;

  typedef struct packed {
    logic        zero;
    logic [31:0] secs;
    logic [15:0] q0;
    logic [17:0] r0;
    logic [15:0] days;
    logic [16:0] rest;
    logic        era_hi;
    logic [17:0] doe;
    logic [4:0]  hour;
    logic [11:0] rh;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  q1460;
    logic [2:0]  q36524;
    logic        q146096;
    logic [17:0] n;
    logic [8:0]  yoe;
    logic [17:0] y365;
    logic [1:0]  y100;
    logic [8:0]  doy;
    logic [10:0] t;
    logic [3:0]  mp;
    logic [10:0] u;
    logic [3:0]  mon;
    logic [8:0]  dsub;
    logic [11:0] year;
    logic [4:0]  mday;
  } pipe_t;

  pipe_t       st [N];
  pipe_t       st_next [N];
  logic [63:0] day_prod;
  logic [8:0]  mday_wide;

  // Approximate day count: the seconds over 128, times the reciprocal of 675.
  assign day_prod = 64'(secs_in[31:7]) * 64'(ucd_pkg::DAY_RCP);
  assign mday_wide = st[12].doy - st[12].dsub + 9'd1;

  always_comb begin
    // Stage 0: first estimate of whole days, at most one too small.
    st_next[0]      = '0;
    st_next[0].zero = (secs_in == 32'd0);
    st_next[0].secs = secs_in;
    st_next[0].q0   = day_prod[ucd_pkg::DAY_SHIFT+15:ucd_pkg::DAY_SHIFT];

    // Stage 1: seconds left over after the estimated days.
    st_next[1]    = st[0];
    st_next[1].r0 = 18'(st[0].secs - 32'(st[0].q0) * ucd_pkg::SECS_PER_DAY);

    // Stage 2: correct the estimate so the leftover is below one day.
    st_next[2] = st[1];
    if (st[1].r0 >= 18'(ucd_pkg::SECS_PER_DAY)) begin
      st_next[2].days = st[1].q0 + 16'd1;
      st_next[2].rest = 17'(st[1].r0 - 18'(ucd_pkg::SECS_PER_DAY));
    end else begin
      st_next[2].days = st[1].q0;
      st_next[2].rest = 17'(st[1].r0);
    end

    // Stage 3: pick the era and the day of era; start the hour.
    st_next[3]        = st[2];
    st_next[3].era_hi = (st[2].days >= ucd_pkg::ERA_SPLIT_DAY);
    if (st_next[3].era_hi) begin
      st_next[3].doe = 18'(st[2].days - ucd_pkg::ERA_SPLIT_DAY);
    end else begin
      st_next[3].doe = 18'(st[2].days) + ucd_pkg::DOE_AT_EPOCH;
    end
    st_next[3].hour = 5'(ucd_pkg::rdiv(32'(st[2].rest), ucd_pkg::RCP_3600));

    // Stage 4: leap corrections of the day of era; seconds within the hour.
    st_next[4]         = st[3];
    st_next[4].q1460   = 7'(ucd_pkg::rdiv(32'(st[3].doe), ucd_pkg::RCP_1460));
    st_next[4].q36524  = 3'(st[3].doe >= 18'(ucd_pkg::DAYS_PER_100Y))
                       + 3'(st[3].doe >= 18'(2 * ucd_pkg::DAYS_PER_100Y))
                       + 3'(st[3].doe >= 18'(3 * ucd_pkg::DAYS_PER_100Y))
                       + 3'(st[3].doe >= 18'(4 * ucd_pkg::DAYS_PER_100Y));
    st_next[4].q146096 = (st[3].doe == 18'(ucd_pkg::DAYS_PER_ERA - 1));
    st_next[4].rh      = 12'(32'(st[3].rest) - 32'(st[3].hour) * ucd_pkg::SECS_PER_HOUR);

    // Stage 5: day of era with leap days taken out; minute.
    st_next[5]        = st[4];
    st_next[5].n      = st[4].doe - 18'(st[4].q1460) + 18'(st[4].q36524)
                      - 18'(st[4].q146096);
    st_next[5].minute = 6'(ucd_pkg::rdiv(32'(st[4].rh), ucd_pkg::RCP_60));

    // Stage 6: year of era; second.
    st_next[6]        = st[5];
    st_next[6].yoe    = 9'(ucd_pkg::rdiv(32'(st[5].n), ucd_pkg::RCP_365));
    st_next[6].second = 6'(st[5].rh - 12'(st[5].minute) * 12'(ucd_pkg::SECS_PER_MIN));

    // Stage 7: days before the start of that year, in two parts.
    st_next[7]      = st[6];
    st_next[7].y365 = 18'(st[6].yoe) * 18'(ucd_pkg::DAYS_PER_YEAR);
    st_next[7].y100 = 2'(ucd_pkg::rdiv(32'(st[6].yoe), ucd_pkg::RCP_100));

    // Stage 8: day of the March-based year.
    st_next[8]     = st[7];
    st_next[8].doy = 9'(st[7].doe - (st[7].y365 + 18'(st[7].yoe[8:2]) - 18'(st[7].y100)));

    // Stage 9: five times the day plus two, as shift and add.
    st_next[9]   = st[8];
    st_next[9].t = (11'(st[8].doy) << 2) + 11'(st[8].doy) + 11'd2;

    // Stage 10: March-based month.
    st_next[10]    = st[9];
    st_next[10].mp = 4'(ucd_pkg::rdiv(32'(st[9].t), ucd_pkg::RCP_153));

    // Stage 11: start of that month, and the month in January-based form.
    st_next[11]   = st[10];
    st_next[11].u = 11'(st[10].mp) * 11'd153 + 11'd2;
    if (st[10].mp < 4'd10) begin
      st_next[11].mon = st[10].mp + 4'd3;
    end else begin
      st_next[11].mon = st[10].mp - 4'd9;
    end

    // Stage 12: days of the year before that month.
    st_next[12]      = st[11];
    st_next[12].dsub = 9'(ucd_pkg::rdiv(32'(st[11].u), ucd_pkg::RCP_5));

    // Stage 13: day of month and year; a zero count gives no date.
    st_next[13]      = st[12];
    st_next[13].mday = 5'(mday_wide);
    st_next[13].year = 12'(st[12].yoe)
                     + (st[12].era_hi ? ucd_pkg::ERA_YEAR_HI : ucd_pkg::ERA_YEAR_LO)
                     + 12'(st[12].mon <= 4'd2);
    if (st[12].zero) begin
      st_next[13].mday = '0;
      st_next[13].year = '0;
      st_next[13].mon  = '0;
    end
  end

  // Each stage holds while it and every stage ahead of it are full and the output is stalled.
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  // The last stage is the result register.
  always_comb begin
    result.date_valid   = !st[N-1].zero;
    result.year         = st[N-1].year;
    result.month        = st[N-1].mon;
    result.day_of_month = st[N-1].mday;
    result.hour         = st[N-1].hour;
    result.minute       = st[N-1].minute;
    result.second       = st[N-1].second;
  end

endmodule

FILE: rtl/core/unix_seconds_to_civil_date_unit.sv
// Top level of the seconds-to-date unit: request handshake and stage valid bits.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// the Gregorian year, month, day, hour, minute and second. A count of zero gives a
// result with date_valid low and all date fields zero. The unit takes one request
// per cycle while the output is not stalled and returns results in request order;
// the work is a chain of constant-reciprocal multiplications (days, hour, minute,
// year, month, day). A stalled output holds the result register, and stages
// behind it keep filling any empty slots, so requests are still accepted until
// every stage holds an item.
module unix_seconds_to_civil_date_unit (
  input logic      clk,
  input logic      rst,
  ucd_in_if.sink   time_in,
  ucd_out_if.source date_out
);

  localparam int unsigned N = ucd_pkg::NSTAGE;

  logic [N-1:0]     vld;
  logic [N-1:0]     adv;
  ucd_pkg::result_t result;

  // A stage moves when the output is taken or some stage at or ahead of it is empty.
  for (genvar k = 0; k < N; k++) begin : g_adv
    assign adv[k] = date_out.ready | ~(&vld[N-1:k]);
  end

  assign time_in.ready = adv[0];

  // Valid bits travel with the payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= time_in.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  ucd_datapath u_datapath (
    .clk     (clk),
    .adv     (adv),
    .secs_in (time_in.epoch_seconds),
    .result  (result)
  );

  // Result register drives the output channel.
  assign date_out.valid        = vld[N-1];
  assign date_out.date_valid   = result.date_valid;
  assign date_out.year         = result.year;
  assign date_out.month        = result.month;
  assign date_out.day_of_month = result.day_of_month;
  assign date_out.hour         = result.hour;
  assign date_out.minute       = result.minute;
  assign date_out.second       = result.second;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the seconds-to-civil-date unit.
`timescale 1ns / 100ps

module tb;

  // Calendar constants of the expected-date arithmetic.
  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;
  localparam int unsigned MIN_SECONDS  = 60;
  localparam int unsigned DAY_OFFSET   = 719468;
  localparam int unsigned ERA_DAYS     = 146097;

  // Run length, stall lengths and watchdog.
  localparam int RANDOM_REQUESTS = 1630;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int IDLE_LIMIT      = 2000;

  // Expected dates in request order, checked against every returned result.
  class civil_date_board;
    ucd_pkg::result_t expected_dates[$];
    int               errors;

    function new();
      errors = 0;
    endfunction

    // Era arithmetic: days split into 400-year eras and March-based years.
    function ucd_pkg::result_t civil_from_seconds(logic [31:0] secs);
      int unsigned      days, rest, z, era, doe, yoe, doy, mp, mon;
      ucd_pkg::result_t r;
      r = '0;
      if (secs == 32'd0) return r;
      days = secs / DAY_SECONDS;
      rest = secs % DAY_SECONDS;
      z    = days + DAY_OFFSET;
      era  = z / ERA_DAYS;
      doe  = z - era * ERA_DAYS;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      r.date_valid   = 1'b1;
      r.year         = 12'(yoe + era * 400 + ((mon <= 2) ? 1 : 0));
      r.month        = 4'(mon);
      r.day_of_month = 5'(doy - (153 * mp + 2) / 5 + 1);
      r.hour         = 5'(rest / HOUR_SECONDS);
      r.minute       = 6'((rest / MIN_SECONDS) % 60);
      r.second       = 6'(rest % 60);
      return r;
    endfunction

    function void note_request(logic [31:0] secs);
      expected_dates.push_back(civil_from_seconds(secs));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ucd_pkg::result_t got);
      ucd_pkg::result_t want;
      if (expected_dates.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_dates.pop_front();
      compare_field("date_valid", want.date_valid, got.date_valid);
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_req;
  int   idle_count;

  civil_date_board board;

  ucd_in_if  time_in_ch ();
  ucd_out_if date_out_ch ();

  unix_seconds_to_civil_date_unit dut (
    .clk      (clk),
    .rst      (rst),
    .time_in  (time_in_ch),
    .date_out (date_out_ch)
  );

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known values on every input from time zero.
  initial begin
    rst                      = 1'b1;
    hold_req                 = 1'b0;
    time_in_ch.valid         = 1'b0;
    time_in_ch.epoch_seconds = 32'd0;
    date_out_ch.ready        = 1'b0;
    board                    = new();
  end

  // Monitor: record accepted requests and check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (time_in_ch.valid && time_in_ch.ready)
        board.note_request(time_in_ch.epoch_seconds);
      if (date_out_ch.valid && date_out_ch.ready)
        board.check_result('{date_valid:   date_out_ch.date_valid,
                             year:         date_out_ch.year,
                             month:        date_out_ch.month,
                             day_of_month: date_out_ch.day_of_month,
                             hour:         date_out_ch.hour,
                             minute:       date_out_ch.minute,
                             second:       date_out_ch.second});
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (time_in_ch.valid && time_in_ch.ready) ||
        (date_out_ch.valid && date_out_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("[unix_seconds_to_civil_date_unit] ERROR");
        $finish;
      end
    end
  end

  // Result side: stall patterns that change every so often, plus a long hold-off on demand.
  initial begin : result_side
    int mode;
    int left;
    int phase;
    mode  = 0;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        date_out_ch.ready = 1'b0;
      end else if (hold_req) begin
        date_out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 120);
        end
        left--;
        phase++;
        case (mode)
          0: begin
            date_out_ch.ready = 1'b1;
          end
          1: begin
            date_out_ch.ready = 1'($urandom_range(0, 1));
          end
          2: begin
            date_out_ch.ready = ($urandom_range(0, 4) == 0);
          end
          default: begin
            date_out_ch.ready = (phase % 3 != 0);
          end
        endcase
      end
    end
  end

  // Offer one request and hold it until it is accepted.
  task automatic send_seconds(input logic [31:0] secs);
    time_in_ch.valid         = 1'b1;
    time_in_ch.epoch_seconds = secs;
    do @(posedge clk); while (!time_in_ch.ready);
    @(negedge clk);
  endtask

  // Leave the request channel idle for a number of cycles.
  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      time_in_ch.valid = 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Random counts weighted toward day, hour, year-end and leap-day boundaries.
  function automatic logic [31:0] random_seconds();
    int unsigned d, y, era, yoe, march_day;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: return $urandom_range(0, 200000);
      5: begin
        d = $urandom_range(1, 49710);
        return d * DAY_SECONDS + $urandom_range(0, 4) - 2;
      end
      6: begin
        d = $urandom_range(0, 49709);
        return d * DAY_SECONDS + $urandom_range(0, 23) * HOUR_SECONDS +
               $urandom_range(0, 59) * MIN_SECONDS + ($urandom_range(0, 1) ? 59 : 0);
      end
      7: begin
        if ($urandom_range(0, 1)) return 32'd0;
        return 32'hFFFF_FFFF - $urandom_range(0, 100000);
      end
      default: begin
        // Day count of March 1 of a random year, then a window around the end of February.
        y         = $urandom_range(1970, 2105);
        era       = y / 400;
        yoe       = y - era * 400;
        march_day = era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 - DAY_OFFSET;
        return march_day * DAY_SECONDS + $urandom_range(0, 2 * DAY_SECONDS) - DAY_SECONDS;
      end
    endcase
  endfunction

  // Request side: reset, directed counts, then random bursts.
  initial begin : request_side
    logic [31:0] directed[$];
    int          burst_left;
    int          n;
    directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                 32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                 32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
                 32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: zero, field extremes, year ends, leap days and the era change.
    foreach (directed[i]) begin
      send_seconds(directed[i]);
      idle_input($urandom_range(0, 2));
    end

    // Random part in bursts of random length.
    burst_left = 0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 600) begin
        // Long hold-off on results while requests keep coming back to back.
        hold_req   = 1'b1;
        burst_left = 60;
      end else if (n == 1100) begin
        // Pause until every outstanding request has returned.
        time_in_ch.valid = 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
      if (burst_left == 0) begin
        idle_input($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 3) == 1 ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
      end
      burst_left--;
      send_seconds(random_seconds());
    end

    // Drain: wait for every result, then a further wait for anything extra.
    time_in_ch.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("[unix_seconds_to_civil_date_unit] OK");
    end else begin
      $display("[unix_seconds_to_civil_date_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: unix_seconds_to_civil_date_unit.f
rtl/core/ucd_pkg.sv
rtl/core/ucd_stream_if.sv
rtl/core/ucd_datapath.sv
rtl/core/unix_seconds_to_civil_date_unit.sv
test/tb.sv
